### hw/rtl/tpmb_pkg.sv
// Shared types, register indexes and arithmetic helpers for the pixel blend unit.
`timescale 1ns / 1ps
`default_nettype none
package tpmb_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned PixW    = 32;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [7:0]         chan_t;
  typedef logic [15:0]        prod_t;
  typedef logic [1:0]         lane_t;

  localparam cfg_idx_t CFG_CONST_COLOR  = 3'd0;
  localparam cfg_idx_t CFG_BLEND_ENABLE = 3'd1;
  localparam cfg_idx_t CFG_RED_LANE     = 3'd2;
  localparam cfg_idx_t CFG_GREEN_LANE   = 3'd3;
  localparam cfg_idx_t CFG_BLUE_LANE    = 3'd4;
  localparam cfg_idx_t CFG_ALPHA_LANE   = 3'd5;

  localparam chan_t CHAN_MAX   = 8'hff;
  localparam prod_t ROUND_HALF = 16'd127;

  // Exact floor(x / 255) for any x below 65280, which covers every product
  // and rounded blend sum that reaches it.
  function automatic chan_t div255(input prod_t x);
    logic [16:0] t;
    t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  function automatic chan_t lane_byte(input logic [PixW-1:0] word, input lane_t lane);
    logic [PixW-1:0] sh;
    sh = word >> {lane, 3'b000};
    return sh[7:0];
  endfunction

  function automatic logic [PixW-1:0] lane_place(input chan_t v, input lane_t lane);
    return {24'b0, v} << {lane, 3'b000};
  endfunction

endpackage
`default_nettype wire

### hw/rtl/tpmb_mix.sv
// One color channel of the source-over blend: product stage and rounding divide.
`timescale 1ns / 1ps
`default_nettype none
module tpmb_mix (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire tpmb_pkg::chan_t src,
  input  wire tpmb_pkg::chan_t dst,
  input  wire tpmb_pkg::chan_t alpha,
  output tpmb_pkg::chan_t     src_q,
  output tpmb_pkg::chan_t     mixed
);
  import tpmb_pkg::*;

  chan_t src_r;
  prod_t sa_r;
  prod_t db_r;
  prod_t sum;

  always_ff @(posedge clk) begin
    if (en) begin
      src_r <= src;
      sa_r  <= prod_t'(src) * prod_t'(alpha);
      db_r  <= prod_t'(dst) * prod_t'(CHAN_MAX - alpha);
    end
  end

  assign sum   = sa_r + db_r + ROUND_HALF;
  assign mixed = div255(sum);
  assign src_q = src_r;

endmodule
`default_nettype wire

### hw/rtl/textured_pixel_modulate_blend_unit.sv
// Top level of the textured pixel modulate and blend unit.
//
//   channel | ports         | tdata (low bit up)            | tuser
//   in      | in_t*         | texel[31:0], dest_pixel[63:32]| opcode
//   out     | out_t*        | pixel_out[31:0]               | write_enable
//   cfg     | cfg_*         | index in cfg_index, cfg_data  | -
//
// One transaction per cycle sustained while out_tready stays high; the four
// register stages (modulate multiply, divide and select, blend multiply,
// rounding divide and pack) lie between input acceptance and out_tvalid.
// Reset clears all stage valid bits and loads the register defaults.
// Each stage holds while its successor is full and stalled; bubbles collapse.
`timescale 1ns / 1ps
`default_nettype none
module textured_pixel_modulate_blend_unit (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [63:0]              in_tdata,   // texel, dest_pixel
  input  wire logic                     in_tuser,   // opcode
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [31:0]                   out_tdata,  // pixel_out
  output logic                          out_tuser,  // write_enable
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire tpmb_pkg::cfg_idx_t       cfg_index,
  input  wire logic [31:0]              cfg_data
);
  import tpmb_pkg::*;

  logic [PixW-1:0] const_color_r;
  logic            blend_en_r;
  lane_t           red_lane_r, green_lane_r, blue_lane_r, alpha_lane_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  logic            op1_r;
  logic [PixW-1:0] tex1_r, dest1_r;
  prod_t           pr1_r, pg1_r, pb1_r, pa1_r;

  chan_t           r2_r, g2_r, b2_r, a2_r;
  logic [PixW-1:0] dest2_r;
  chan_t           r2_nxt, g2_nxt, b2_nxt, a2_nxt;

  chan_t           a3_r;
  logic [PixW-1:0] dest3_r;
  chan_t           sr3, sg3, sb3, mr3, mg3, mb3;

  logic [PixW-1:0] pix4_r, pix4_nxt;
  logic            we4_r;

  chan_t           kr, kg, kb, ka;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      const_color_r <= 32'hffff_ffff;
      blend_en_r    <= 1'b0;
      red_lane_r    <= 2'd0;
      green_lane_r  <= 2'd1;
      blue_lane_r   <= 2'd2;
      alpha_lane_r  <= 2'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CONST_COLOR:  const_color_r <= cfg_data;
        CFG_BLEND_ENABLE: blend_en_r    <= cfg_data[0];
        CFG_RED_LANE:     red_lane_r    <= cfg_data[1:0];
        CFG_GREEN_LANE:   green_lane_r  <= cfg_data[1:0];
        CFG_BLUE_LANE:    blue_lane_r   <= cfg_data[1:0];
        CFG_ALPHA_LANE:   alpha_lane_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign kr = const_color_r[7:0];
  assign kg = const_color_r[15:8];
  assign kb = const_color_r[23:16];
  assign ka = const_color_r[31:24];

  assign en4 = !v4_r || out_tready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      op1_r   <= in_tuser;
      tex1_r  <= in_tdata[31:0];
      dest1_r <= in_tdata[63:32];
      pr1_r   <= prod_t'(in_tdata[7:0])   * prod_t'(kr);
      pg1_r   <= prod_t'(in_tdata[15:8])  * prod_t'(kg);
      pb1_r   <= prod_t'(in_tdata[23:16]) * prod_t'(kb);
      pa1_r   <= prod_t'(in_tdata[31:24]) * prod_t'(ka);
    end
  end

  always_comb begin
    priority if (!op1_r) begin
      r2_nxt = kr;
      g2_nxt = kg;
      b2_nxt = kb;
      a2_nxt = ka;
    end else if (&const_color_r) begin
      r2_nxt = tex1_r[7:0];
      g2_nxt = tex1_r[15:8];
      b2_nxt = tex1_r[23:16];
      a2_nxt = tex1_r[31:24];
    end else begin
      r2_nxt = div255(pr1_r);
      g2_nxt = div255(pg1_r);
      b2_nxt = div255(pb1_r);
      a2_nxt = div255(pa1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      r2_r    <= r2_nxt;
      g2_r    <= g2_nxt;
      b2_r    <= b2_nxt;
      a2_r    <= a2_nxt;
      dest2_r <= dest1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      a3_r    <= a2_r;
      dest3_r <= dest2_r;
    end
  end

  tpmb_mix u_mix_r (
    .clk(clk), .en(en3), .src(r2_r), .dst(lane_byte(dest2_r, red_lane_r)),
    .alpha(a2_r), .src_q(sr3), .mixed(mr3)
  );

  tpmb_mix u_mix_g (
    .clk(clk), .en(en3), .src(g2_r), .dst(lane_byte(dest2_r, green_lane_r)),
    .alpha(a2_r), .src_q(sg3), .mixed(mg3)
  );

  tpmb_mix u_mix_b (
    .clk(clk), .en(en3), .src(b2_r), .dst(lane_byte(dest2_r, blue_lane_r)),
    .alpha(a2_r), .src_q(sb3), .mixed(mb3)
  );

  always_comb begin
    priority if (a3_r == 8'd0) begin
      pix4_nxt = dest3_r;
    end else if (!blend_en_r || a3_r == CHAN_MAX) begin
      pix4_nxt = lane_place(sr3, red_lane_r) | lane_place(sg3, green_lane_r)
               | lane_place(sb3, blue_lane_r) | lane_place(CHAN_MAX, alpha_lane_r);
    end else begin
      pix4_nxt = lane_place(mr3, red_lane_r) | lane_place(mg3, green_lane_r)
               | lane_place(mb3, blue_lane_r) | lane_place(CHAN_MAX, alpha_lane_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      pix4_r <= pix4_nxt;
      we4_r  <= (a3_r != 8'd0);
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = pix4_r;
  assign out_tuser  = we4_r;

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !v1_r && !v2_r && !v3_r && !v4_r)
    else $error("pipeline valid bits not cleared by reset");

  a_alpha_lane: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> lane_byte(out_tdata, alpha_lane_r) == CHAN_MAX)
    else $error("written pixel lacks opaque alpha lane");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r && !v2_r && !v3_r && !v4_r |-> in_tready)
    else $error("empty pipeline refuses input");

  a_no_write_keeps_dest: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && en4 && a3_r == 8'd0 |=> v4_r && !out_tuser && out_tdata == $past(dest3_r))
    else $error("zero alpha transaction altered destination");
`endif

endmodule
`default_nettype wire
